### rtl/cpcp_pkg.sv
`default_nettype none

package cpcp_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int OUT_BITS      = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int CFG_BITS      = 32;
    localparam int CFG_ADDR_BITS = 2;
    localparam int TURN_BITS     = 32;
    localparam int XY_BITS       = 34;
    localparam int STAGE_BITS    = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int TBL_IDX_BITS  = 5;
    localparam int FIN_SHIFT     = 31 - OUT_BITS;

    typedef logic [PHASE_BITS-1:0] acc_t;
    typedef logic signed [XY_BITS-1:0] xy_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_START_PHASE        = 2'd0,
        REG_START_FREQUENCY    = 2'd1,
        REG_START_ACCELERATION = 2'd2,
        REG_ACCELERATION_RATE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        acc_t phi;
        acc_t rate;
        acc_t change;
        acc_t adot;
    } acc_load_t;

    typedef struct packed {
        logic                 valid;
        logic                 neg;
        logic [TURN_BITS-1:0] phase;
        xy_t                  x;
        xy_t                  y;
        xy_t                  ang;
    } cordic_beat_t;

    localparam xy_t X_START = xy_t'(64'sh26DD3B6A);
    localparam xy_t QUARTER = xy_t'(64'sd1 <<< 30);
    localparam xy_t HALF    = xy_t'(64'sd1 <<< 31);

    function automatic acc_t sext_acc(input logic [CFG_BITS-1:0] v);
        logic signed [63:0] t;
        t = 64'(signed'(v));
        return t[PHASE_BITS-1:0];
    endfunction

    function automatic logic [TURN_BITS-1:0] phase_to_turn(input acc_t p);
        logic [PHASE_BITS+TURN_BITS-1:0] w;
        w = {p, {TURN_BITS{1'b0}}};
        return w[PHASE_BITS+TURN_BITS-1 -: TURN_BITS];
    endfunction

    function automatic xy_t atan_turn(input logic [TBL_IDX_BITS-1:0] idx);
        xy_t a;
        case (idx)
            5'd0:    a = xy_t'(64'sd536870912);
            5'd1:    a = xy_t'(64'sd316933406);
            5'd2:    a = xy_t'(64'sd167458907);
            5'd3:    a = xy_t'(64'sd85004756);
            5'd4:    a = xy_t'(64'sd42667331);
            5'd5:    a = xy_t'(64'sd21354465);
            5'd6:    a = xy_t'(64'sd10679838);
            5'd7:    a = xy_t'(64'sd5340245);
            5'd8:    a = xy_t'(64'sd2670163);
            5'd9:    a = xy_t'(64'sd1335087);
            5'd10:   a = xy_t'(64'sd667544);
            5'd11:   a = xy_t'(64'sd333772);
            5'd12:   a = xy_t'(64'sd166886);
            5'd13:   a = xy_t'(64'sd83443);
            5'd14:   a = xy_t'(64'sd41722);
            5'd15:   a = xy_t'(64'sd20861);
            5'd16:   a = xy_t'(64'sd10430);
            5'd17:   a = xy_t'(64'sd5215);
            5'd18:   a = xy_t'(64'sd2608);
            5'd19:   a = xy_t'(64'sd1304);
            5'd20:   a = xy_t'(64'sd652);
            5'd21:   a = xy_t'(64'sd326);
            5'd22:   a = xy_t'(64'sd163);
            5'd23:   a = xy_t'(64'sd81);
            default: a = xy_t'(64'sd0);
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/cubic_phase_chirp_phasor.sv
// Path: input beat -> phase register -> CORDIC cells -> output register.
// Throughput: one beat per cycle unless stalled; difference accumulators step per accepted beat.
// The rotation pipeline holds whenever the output register is full and not taken.
// Reset (rst_n low, asynchronous): config regs, accumulators and valid flags clear; pipeline empties;
// the first beat after reset loads the accumulators from configuration.
`default_nettype none

module cubic_phase_chirp_phasor (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cpcp_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [cpcp_pkg::CFG_BITS-1:0]       cfg_wr_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [0] restart
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [63:0]                              m_axis_tdata   // cosine_out, sine_out, phase_out
);

    localparam int N = cpcp_pkg::CORDIC_STAGES;

    logic [cpcp_pkg::CFG_BITS-1:0] start_phase_reg;
    logic [cpcp_pkg::CFG_BITS-1:0] start_frequency_reg;
    logic [cpcp_pkg::CFG_BITS-1:0] start_acceleration_reg;
    logic [cpcp_pkg::CFG_BITS-1:0] acceleration_rate_reg;
    logic [cpcp_pkg::CFG_BITS-1:0] adot_div6_reg;

    function automatic logic [31:0] div6(input logic [31:0] d);
        logic [31:0] mag;
        logic [63:0] prod;
        logic [31:0] q;
        mag  = d[31] ? (32'd0 - d) : d;
        prod = 64'(mag) * 64'(32'hAAAAAAAB);
        q    = 32'(prod[63:34]);
        return d[31] ? (32'd0 - q) : q;
    endfunction

    function automatic logic [cpcp_pkg::OUT_BITS-1:0] finish(input cpcp_pkg::xy_t v,
                                                             input logic neg);
        cpcp_pkg::xy_t t, r, lim;
        t   = v + cpcp_pkg::xy_t'(64'sd1 <<< (cpcp_pkg::FIN_SHIFT - 1));
        r   = t >>> cpcp_pkg::FIN_SHIFT;
        lim = cpcp_pkg::xy_t'((64'sd1 <<< (cpcp_pkg::OUT_BITS - 1)) - 64'sd1);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        if (neg)
            r = -r;
        return r[cpcp_pkg::OUT_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_phase_reg        <= '0;
            start_frequency_reg    <= '0;
            start_acceleration_reg <= '0;
            acceleration_rate_reg  <= '0;
            adot_div6_reg          <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                cpcp_pkg::REG_START_PHASE:        start_phase_reg        <= cfg_wr_data;
                cpcp_pkg::REG_START_FREQUENCY:    start_frequency_reg    <= cfg_wr_data;
                cpcp_pkg::REG_START_ACCELERATION: start_acceleration_reg <= cfg_wr_data;
                cpcp_pkg::REG_ACCELERATION_RATE:
                begin
                    acceleration_rate_reg <= cfg_wr_data;
                    adot_div6_reg         <= div6(cfg_wr_data);
                end
                default: ;
            endcase
        end
    end

    logic                enable;
    logic                s_fire;
    logic                out_valid_reg;
    cpcp_pkg::acc_load_t load_vals;
    cpcp_pkg::acc_t      phase_cur;
    cpcp_pkg::acc_t      w0, a0, a0_half, ad, ad6;

    assign enable        = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = enable;
    assign s_fire        = s_axis_tvalid & enable;

    always_comb
    begin
        w0      = cpcp_pkg::sext_acc(start_frequency_reg);
        a0      = cpcp_pkg::sext_acc(start_acceleration_reg);
        a0_half = cpcp_pkg::sext_acc({start_acceleration_reg[31], start_acceleration_reg[31:1]});
        ad      = cpcp_pkg::sext_acc(acceleration_rate_reg);
        ad6     = cpcp_pkg::sext_acc(adot_div6_reg);

        load_vals.phi    = cpcp_pkg::acc_t'({{32{1'b0}}, start_phase_reg});
        load_vals.rate   = w0 + a0_half + ad6;
        load_vals.change = a0 + ad;
        load_vals.adot   = ad;
    end

    cpcp_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s_fire),
        .restart   (s_axis_tdata[0]),
        .load_vals (load_vals),
        .phase_cur (phase_cur)
    );

    logic                            valid0_reg;
    logic [cpcp_pkg::TURN_BITS-1:0]  phase0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid0_reg <= s_fire;
            phase0_reg <= cpcp_pkg::phase_to_turn(phase_cur);
        end
    end

    cpcp_pkg::cordic_beat_t beat [0:N];
    cpcp_pkg::cordic_beat_t beat_in;
    cpcp_pkg::xy_t          ang0;

    always_comb
    begin
        ang0 = cpcp_pkg::xy_t'(signed'(phase0_reg));
        beat_in.valid = valid0_reg;
        beat_in.phase = phase0_reg;
        beat_in.x     = cpcp_pkg::X_START;
        beat_in.y     = '0;
        beat_in.neg   = 1'b0;
        beat_in.ang   = ang0;
        if (ang0 >= cpcp_pkg::QUARTER)
        begin
            beat_in.ang = ang0 - cpcp_pkg::HALF;
            beat_in.neg = 1'b1;
        end
        else if (ang0 < -cpcp_pkg::QUARTER)
        begin
            beat_in.ang = ang0 + cpcp_pkg::HALF;
            beat_in.neg = 1'b1;
        end
    end

    assign beat[0] = beat_in;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            cpcp_cordic_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .enable    (enable),
                .stage_idx (cpcp_pkg::STAGE_BITS'(g)),
                .din       (beat[g]),
                .dout      (beat[g+1])
            );
        end
    endgenerate

    logic [cpcp_pkg::OUT_BITS-1:0]  cos_reg;
    logic [cpcp_pkg::OUT_BITS-1:0]  sin_reg;
    logic [cpcp_pkg::TURN_BITS-1:0] phase_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            out_valid_reg <= beat[N].valid;
            cos_reg       <= finish(beat[N].x, beat[N].neg);
            sin_reg       <= finish(beat[N].y, beat[N].neg);
            phase_out_reg <= beat[N].phase;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {phase_out_reg, sin_reg, cos_reg};

endmodule

`default_nettype wire

### rtl/cpcp_acc.sv
`default_nettype none

module cpcp_acc (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               restart,
    input  wire cpcp_pkg::acc_load_t load_vals,
    output cpcp_pkg::acc_t          phase_cur
);

    cpcp_pkg::acc_t phase_acc_reg, phase_acc_next;
    cpcp_pkg::acc_t rate_acc_reg, rate_acc_next;
    cpcp_pkg::acc_t change_acc_reg, change_acc_next;
    logic           started_reg, started_next;

    logic           load;
    cpcp_pkg::acc_t rate_cur;
    cpcp_pkg::acc_t change_cur;

    always_comb
    begin
        load       = restart | ~started_reg;
        phase_cur  = load ? load_vals.phi    : phase_acc_reg;
        rate_cur   = load ? load_vals.rate   : rate_acc_reg;
        change_cur = load ? load_vals.change : change_acc_reg;

        phase_acc_next  = phase_acc_reg;
        rate_acc_next   = rate_acc_reg;
        change_acc_next = change_acc_reg;
        started_next    = started_reg;
        if (advance)
        begin
            phase_acc_next  = phase_cur + rate_cur;
            rate_acc_next   = rate_cur + change_cur;
            change_acc_next = change_cur + load_vals.adot;
            started_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg  <= '0;
            rate_acc_reg   <= '0;
            change_acc_reg <= '0;
            started_reg    <= 1'b0;
        end
        else
        begin
            phase_acc_reg  <= phase_acc_next;
            rate_acc_reg   <= rate_acc_next;
            change_acc_reg <= change_acc_next;
            started_reg    <= started_next;
        end
    end

endmodule

`default_nettype wire

### rtl/cpcp_cordic_cell.sv
`default_nettype none

module cpcp_cordic_cell (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                enable,
    input  wire logic [cpcp_pkg::STAGE_BITS-1:0]     stage_idx,
    input  wire cpcp_pkg::cordic_beat_t              din,
    output cpcp_pkg::cordic_beat_t                   dout
);

    cpcp_pkg::cordic_beat_t beat_reg, beat_next;

    cpcp_pkg::xy_t x_in, y_in, ang_in, x_sh, y_sh, atan_c;

    always_comb
    begin
        x_in   = din.x;
        y_in   = din.y;
        ang_in = din.ang;
        x_sh   = x_in >>> stage_idx;
        y_sh   = y_in >>> stage_idx;
        atan_c = cpcp_pkg::atan_turn(cpcp_pkg::TBL_IDX_BITS'(stage_idx));

        beat_next = din;
        if (!ang_in[cpcp_pkg::XY_BITS-1])
        begin
            beat_next.x   = x_in - y_sh;
            beat_next.y   = y_in + x_sh;
            beat_next.ang = ang_in - atan_c;
        end
        else
        begin
            beat_next.x   = x_in + y_sh;
            beat_next.y   = y_in - x_sh;
            beat_next.ang = ang_in + atan_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg.valid <= 1'b0;
        end
        else if (enable)
        begin
            beat_reg <= beat_next;
        end
    end

    assign dout = beat_reg;

endmodule

`default_nettype wire
